FILE: design/gbi_pkg.sv
// gbi_pkg: shared types, codes and helpers of the gravity body integrator
// no dependencies
`default_nettype none

package gbi_pkg;

  typedef enum logic [1:0] {
    ACT_GRAVITY = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_UNUSED  = 2'd3
  } gbi_action_e;

  typedef enum logic [2:0] {
    CFG_START_POS_X = 3'd0,
    CFG_START_POS_Y = 3'd1,
    CFG_START_VEL_X = 3'd2,
    CFG_START_VEL_Y = 3'd3,
    CFG_OWN_MASS    = 3'd4,
    CFG_GRAV_SCALE  = 3'd5
  } gbi_cfg_idx_e;

  localparam logic [47:0] GRAV_SCALE_RESET = 48'd18774;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIFF, ST_MUL_X2, ST_MUL_Y2, ST_SUM_SQ, ST_MUL_GL, ST_MUL_GH,
    ST_SUM_GM, ST_START_MAG, ST_WAIT_MAG, ST_MUL_CX, ST_START_CX, ST_WAIT_CX,
    ST_ACC_X, ST_MUL_CY, ST_START_CY, ST_WAIT_CY, ST_ACC_Y, ST_TICK_V,
    ST_TICK_P, ST_RESTART, ST_FINISH
  } gbi_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIFF, OP_MUL_X2, OP_MUL_Y2, OP_SUM_SQ, OP_MUL_GL,
    OP_MUL_GH, OP_SUM_GM, OP_START_MAG, OP_MUL_CX, OP_START_CX, OP_ACC_X,
    OP_MUL_CY, OP_START_CY, OP_ACC_Y, OP_TICK_V, OP_TICK_P, OP_RESTART, OP_OUT
  } gbi_op_e;

  typedef struct packed {
    gbi_op_e op;
  } gbi_cmd_t;

  typedef struct packed {
    logic zero_dist;
    logic mag_done;
    logic div_done;
  } gbi_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/gbi_if.sv
// gbi interfaces: input item, result item and configuration write channels
// no dependencies
`default_nettype none

interface gbi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] other_x;
  logic signed [31:0] other_y;
  logic [31:0]        other_mass;
  modport source (output valid, action, other_x, other_y, other_mass, input ready);
  modport sink (input valid, action, other_x, other_y, other_mass, output ready);
endinterface

interface gbi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic               coincident;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, coincident, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, coincident, output ready);
endinterface

interface gbi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/gbi_div.sv
// gbi_div: restoring divider, one quotient bit per cycle, saturates to 2^31-1
// no dependencies
`default_nettype none

module gbi_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [79:0] num_i,
  input  wire logic [77:0] den_i,
  output logic             done_o,
  output logic [30:0]      quot_o
);

  logic         busy_q, busy_d;
  logic [4:0]   cnt_q, cnt_d;
  logic [79:0]  rem_q, rem_d;
  logic [108:0] dsr_q, dsr_d;
  logic [31:0]  quot_q, quot_d;
  logic         ge;

  // divisor starts at bit 31: a set top bit means the quotient saturates
  assign ge = {29'd0, rem_q} >= dsr_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      rem_d  = num_i;
      dsr_d  = {den_i, 31'd0};
      quot_d = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsr_q[79:0];
      end
      quot_d = {quot_q[30:0], ge};
      dsr_d  = {1'b0, dsr_q[108:1]};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
  end

  assign done_o = !busy_q;
  assign quot_o = quot_q[31] ? 31'h7fffffff : quot_q[30:0];

endmodule

`default_nettype wire

FILE: design/gbi_sqrt.sv
// gbi_sqrt: digit-by-digit integer square root, one root bit per cycle
// no dependencies
`default_nettype none

module gbi_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [65:0] val_i,
  output logic             done_o,
  output logic [32:0]      root_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [65:0] val_q, val_d;
  logic [34:0] rem_q, rem_d;
  logic [32:0] root_q, root_d;
  logic [36:0] rem_sh, trial, rem_sub;
  logic        ge;

  assign rem_sh  = {rem_q, val_q[65:64]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      val_d  = val_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      val_d  = {val_q[63:0], 2'b00};
      // remainder stays below 2*root+1, so 35 bits hold it
      rem_d  = ge ? rem_sub[34:0] : rem_sh[34:0];
      root_d = {root_q[31:0], ge};
      cnt_d  = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = !busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: design/gbi_datapath.sv
// gbi_datapath: body state, config registers, shared multiplier, divider, root
// depends on gbi_pkg, gbi_div, gbi_sqrt
`default_nettype none

module gbi_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gbi_pkg::gbi_cmd_t  cmd_i,
  output gbi_pkg::gbi_status_t    status_o,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [31:0] other_x_i,
  input  wire logic signed [31:0] other_y_i,
  input  wire logic [31:0]        other_mass_i,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [47:0]        cfg_data_i,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      vel_x_o,
  output logic signed [31:0]      vel_y_o,
  output logic                    coincident_o
);

  logic signed [31:0] spx_q, spy_q, svx_q, svy_q;
  logic [47:0]        gs_q;
  logic signed [31:0] px_q, py_q, vx_q, vy_q, ax_q, ay_q;
  logic [1:0]         act_q;
  logic signed [31:0] ox_q, oy_q;
  logic [31:0]        om_q;
  logic signed [32:0] dx_q, dy_q;
  logic [32:0]        adx, ady;
  logic [32:0]        mul_a, mul_b;
  logic [65:0]        prod_q, sq_q;
  logic [79:0]        gm_q;
  logic [30:0]        mag_q;
  logic               div_start, sqrt_start, div_done, sqrt_done;
  logic [79:0]        div_num;
  logic [77:0]        div_den;
  logic [30:0]        div_q;
  logic [32:0]        root;
  logic signed [32:0] comp;
  logic signed [31:0] vx_new, vy_new;
  gbi_pkg::gbi_op_e   op;

  assign op  = cmd_i.op;
  assign adx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign ady = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);

  // own mass cancels out of the acceleration, so a write to it is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spx_q <= '0;
      spy_q <= '0;
      svx_q <= '0;
      svy_q <= '0;
      gs_q  <= gbi_pkg::GRAV_SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gbi_pkg::CFG_START_POS_X: spx_q <= cfg_data_i[31:0];
        gbi_pkg::CFG_START_POS_Y: spy_q <= cfg_data_i[31:0];
        gbi_pkg::CFG_START_VEL_X: svx_q <= cfg_data_i[31:0];
        gbi_pkg::CFG_START_VEL_Y: svy_q <= cfg_data_i[31:0];
        gbi_pkg::CFG_GRAV_SCALE:  gs_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared 33x33 multiplier, operands picked by the current step
  always_comb begin
    unique case (op)
      gbi_pkg::OP_MUL_X2: begin mul_a = adx; mul_b = adx; end
      gbi_pkg::OP_MUL_Y2: begin mul_a = ady; mul_b = ady; end
      gbi_pkg::OP_MUL_GL: begin mul_a = {9'd0, gs_q[23:0]};  mul_b = {1'b0, om_q}; end
      gbi_pkg::OP_MUL_GH: begin mul_a = {9'd0, gs_q[47:24]}; mul_b = {1'b0, om_q}; end
      gbi_pkg::OP_MUL_CX: begin mul_a = {2'd0, div_q}; mul_b = adx; end
      gbi_pkg::OP_MUL_CY: begin mul_a = {2'd0, mag_q}; mul_b = ady; end
      default:            begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  assign div_start  = (op == gbi_pkg::OP_START_MAG) || (op == gbi_pkg::OP_START_CX) ||
                      (op == gbi_pkg::OP_START_CY);
  assign sqrt_start = (op == gbi_pkg::OP_START_MAG);
  assign div_num    = (op == gbi_pkg::OP_START_MAG) ? gm_q : {14'd0, prod_q};
  assign div_den    = (op == gbi_pkg::OP_START_MAG) ? {sq_q, 12'd0} : {45'd0, root};

  gbi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  gbi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (sq_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign comp   = (op == gbi_pkg::OP_ACC_X ? dx_q[32] : dy_q[32]) ?
                  -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
  assign vx_new = gbi_pkg::sat32(33'(vx_q) + 33'(ax_q));
  assign vy_new = gbi_pkg::sat32(33'(vy_q) + 33'(ay_q));

  always_ff @(posedge clk_i) begin
    unique case (op)
      gbi_pkg::OP_LOAD: begin
        act_q <= action_i;
        ox_q  <= other_x_i;
        oy_q  <= other_y_i;
        om_q  <= other_mass_i;
      end
      gbi_pkg::OP_DIFF: begin
        dx_q <= 33'(ox_q) - 33'(px_q);
        dy_q <= 33'(oy_q) - 33'(py_q);
      end
      gbi_pkg::OP_MUL_Y2: sq_q <= prod_q;
      gbi_pkg::OP_SUM_SQ: sq_q <= sq_q + prod_q;
      gbi_pkg::OP_MUL_GH: gm_q <= {14'd0, prod_q};
      gbi_pkg::OP_SUM_GM: gm_q <= gm_q + {prod_q[55:0], 24'd0};
      gbi_pkg::OP_MUL_CX: mag_q <= div_q;
      gbi_pkg::OP_OUT: begin
        pos_x_o      <= px_q;
        pos_y_o      <= py_q;
        vel_x_o      <= vx_q;
        vel_y_o      <= vy_q;
        coincident_o <= (act_q == gbi_pkg::ACT_GRAVITY) && (dx_q == '0) && (dy_q == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
      vx_q <= '0;
      vy_q <= '0;
      ax_q <= '0;
      ay_q <= '0;
    end else begin
      unique case (op)
        gbi_pkg::OP_ACC_X: ax_q <= gbi_pkg::sat32(33'(ax_q) + comp);
        gbi_pkg::OP_ACC_Y: ay_q <= gbi_pkg::sat32(33'(ay_q) + comp);
        gbi_pkg::OP_TICK_V: begin
          vx_q <= vx_new;
          vy_q <= vy_new;
        end
        gbi_pkg::OP_TICK_P: begin
          px_q <= gbi_pkg::sat32(33'(px_q) + 33'(vx_q));
          py_q <= gbi_pkg::sat32(33'(py_q) + 33'(vy_q));
          ax_q <= '0;
          ay_q <= '0;
        end
        gbi_pkg::OP_RESTART: begin
          px_q <= spx_q;
          py_q <= spy_q;
          vx_q <= svx_q;
          vy_q <= svy_q;
          ax_q <= '0;
          ay_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign status_o.zero_dist = (dx_q == '0) && (dy_q == '0);
  assign status_o.mag_done  = div_done && sqrt_done;
  assign status_o.div_done  = div_done;

endmodule

`default_nettype wire

FILE: design/gbi_ctrl.sv
// gbi_ctrl: sequencer that steps the datapath and drives both handshakes
// depends on gbi_pkg
`default_nettype none

module gbi_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [1:0]           in_action_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire gbi_pkg::gbi_status_t status_i,
  output gbi_pkg::gbi_cmd_t         cmd_o
);

  gbi_pkg::gbi_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbi_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = gbi_pkg::OP_NONE;
    in_ready_o  = 1'b0;
    unique case (state_q)
      gbi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = gbi_pkg::OP_LOAD;
          unique case (in_action_i)
            gbi_pkg::ACT_GRAVITY: state_d = gbi_pkg::ST_DIFF;
            gbi_pkg::ACT_TICK:    state_d = gbi_pkg::ST_TICK_V;
            gbi_pkg::ACT_RESTART: state_d = gbi_pkg::ST_RESTART;
            default:              state_d = gbi_pkg::ST_FINISH;
          endcase
        end
      end
      gbi_pkg::ST_DIFF: begin
        cmd_o.op = gbi_pkg::OP_DIFF;
        state_d  = gbi_pkg::ST_MUL_X2;
      end
      gbi_pkg::ST_MUL_X2: begin
        // coincident body leaves the state alone
        if (status_i.zero_dist) begin
          state_d = gbi_pkg::ST_FINISH;
        end else begin
          cmd_o.op = gbi_pkg::OP_MUL_X2;
          state_d  = gbi_pkg::ST_MUL_Y2;
        end
      end
      gbi_pkg::ST_MUL_Y2: begin
        cmd_o.op = gbi_pkg::OP_MUL_Y2;
        state_d  = gbi_pkg::ST_SUM_SQ;
      end
      gbi_pkg::ST_SUM_SQ: begin
        cmd_o.op = gbi_pkg::OP_SUM_SQ;
        state_d  = gbi_pkg::ST_MUL_GL;
      end
      gbi_pkg::ST_MUL_GL: begin
        cmd_o.op = gbi_pkg::OP_MUL_GL;
        state_d  = gbi_pkg::ST_MUL_GH;
      end
      gbi_pkg::ST_MUL_GH: begin
        cmd_o.op = gbi_pkg::OP_MUL_GH;
        state_d  = gbi_pkg::ST_SUM_GM;
      end
      gbi_pkg::ST_SUM_GM: begin
        cmd_o.op = gbi_pkg::OP_SUM_GM;
        state_d  = gbi_pkg::ST_START_MAG;
      end
      gbi_pkg::ST_START_MAG: begin
        cmd_o.op = gbi_pkg::OP_START_MAG;
        state_d  = gbi_pkg::ST_WAIT_MAG;
      end
      gbi_pkg::ST_WAIT_MAG: begin
        if (status_i.mag_done) state_d = gbi_pkg::ST_MUL_CX;
      end
      gbi_pkg::ST_MUL_CX: begin
        cmd_o.op = gbi_pkg::OP_MUL_CX;
        state_d  = gbi_pkg::ST_START_CX;
      end
      gbi_pkg::ST_START_CX: begin
        cmd_o.op = gbi_pkg::OP_START_CX;
        state_d  = gbi_pkg::ST_WAIT_CX;
      end
      gbi_pkg::ST_WAIT_CX: begin
        if (status_i.div_done) state_d = gbi_pkg::ST_ACC_X;
      end
      gbi_pkg::ST_ACC_X: begin
        cmd_o.op = gbi_pkg::OP_ACC_X;
        state_d  = gbi_pkg::ST_MUL_CY;
      end
      gbi_pkg::ST_MUL_CY: begin
        cmd_o.op = gbi_pkg::OP_MUL_CY;
        state_d  = gbi_pkg::ST_START_CY;
      end
      gbi_pkg::ST_START_CY: begin
        cmd_o.op = gbi_pkg::OP_START_CY;
        state_d  = gbi_pkg::ST_WAIT_CY;
      end
      gbi_pkg::ST_WAIT_CY: begin
        if (status_i.div_done) state_d = gbi_pkg::ST_ACC_Y;
      end
      gbi_pkg::ST_ACC_Y: begin
        cmd_o.op = gbi_pkg::OP_ACC_Y;
        state_d  = gbi_pkg::ST_FINISH;
      end
      gbi_pkg::ST_TICK_V: begin
        cmd_o.op = gbi_pkg::OP_TICK_V;
        state_d  = gbi_pkg::ST_TICK_P;
      end
      gbi_pkg::ST_TICK_P: begin
        cmd_o.op = gbi_pkg::OP_TICK_P;
        state_d  = gbi_pkg::ST_FINISH;
      end
      gbi_pkg::ST_RESTART: begin
        cmd_o.op = gbi_pkg::OP_RESTART;
        state_d  = gbi_pkg::ST_FINISH;
      end
      gbi_pkg::ST_FINISH: begin
        // result register free or being emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = gbi_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = gbi_pkg::ST_IDLE;
        end
      end
      default: state_d = gbi_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: design/gravity_body_integrator.sv
// gravity body integrator: one item at a time; a gravity word is mostly the 33-step root
// (run beside the 32-step force division) and two 32-step component divisions; a tick word
// updates velocity, then position; restart reloads the start values, unused goes to the result.
// a result waits in the output register while the next word is taken.
// rst_ni clears position, velocity and acceleration, and sets the config defaults.
// depends on gbi_pkg, gbi_if, gbi_ctrl, gbi_datapath
`default_nettype none

module gravity_body_integrator (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gbi_in_if.sink    in_i,
  gbi_out_if.source out_o,
  gbi_cfg_if.sink   cfg_i
);

  gbi_pkg::gbi_cmd_t    cmd;
  gbi_pkg::gbi_status_t status;

  assign cfg_i.ready = 1'b1;

  gbi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gbi_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .action_i     (in_i.action),
    .other_x_i    (in_i.other_x),
    .other_y_i    (in_i.other_y),
    .other_mass_i (in_i.other_mass),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .pos_x_o      (out_o.pos_x),
    .pos_y_o      (out_o.pos_y),
    .vel_x_o      (out_o.vel_x),
    .vel_y_o      (out_o.vel_y),
    .coincident_o (out_o.coincident)
  );

endmodule

`default_nettype wire

FILE: bench/gbi_checker.sv
// gbi_checker: watches the input, result and configuration channels of the
// gravity body integrator, predicts every result word and compares it
// depends on gbi_pkg and gbi_if
`default_nettype none

module gbi_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gbi_in_if         in_w,
  gbi_out_if        out_w,
  gbi_cfg_if        cfg_w,
  output int        fail_count,
  output int        pending
);

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               coincident;
  } body_word_t;

  // shadow registers and body state, own mass cancels out of every result
  logic signed [31:0] cfg_pos_x, cfg_pos_y, cfg_vel_x, cfg_vel_y;
  logic [47:0]        cfg_grav;
  logic signed [31:0] body_px, body_py, body_vx, body_vy, body_ax, body_ay;

  body_word_t body_state_q[$];

  assign pending = body_state_q.size();

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [127:0] root_floor(input logic [127:0] v);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // pull of one body on the acceleration, along each axis
  task automatic add_pull(input logic signed [31:0] ox, input logic signed [31:0] oy,
                          input logic [31:0] om, output logic coin);
    longint       dx, dy;
    logic [127:0] adx, ady, sq, den, num, q, mag, s, cx, cy;
    dx = longint'(ox) - longint'(body_px);
    dy = longint'(oy) - longint'(body_py);
    coin = 1'b0;
    if (dx == 0 && dy == 0) begin
      coin = 1'b1;
      return;
    end
    adx = dx < 0 ? 128'(-dx) : 128'(dx);
    ady = dy < 0 ? 128'(-dy) : 128'(dy);
    sq  = adx * adx + ady * ady;
    den = sq << 12;
    num = 128'(cfg_grav) * 128'(om);
    q   = num / den;
    mag = q > 128'd2147483647 ? 128'd2147483647 : q;
    s   = root_floor(sq);
    cx  = (mag * adx) / s;
    cy  = (mag * ady) / s;
    body_ax = clamp32(longint'(body_ax) + (dx < 0 ? -longint'(cx) : longint'(cx)));
    body_ay = clamp32(longint'(body_ay) + (dy < 0 ? -longint'(cy) : longint'(cy)));
  endtask

  task automatic advance_body(input logic [1:0] act, input logic signed [31:0] ox,
                              input logic signed [31:0] oy, input logic [31:0] om,
                              output body_word_t w);
    logic coin;
    coin = 1'b0;
    case (gbi_pkg::gbi_action_e'(act))
      gbi_pkg::ACT_GRAVITY: begin
        add_pull(ox, oy, om, coin);
      end
      gbi_pkg::ACT_TICK: begin
        body_vx = clamp32(longint'(body_vx) + longint'(body_ax));
        body_vy = clamp32(longint'(body_vy) + longint'(body_ay));
        body_px = clamp32(longint'(body_px) + longint'(body_vx));
        body_py = clamp32(longint'(body_py) + longint'(body_vy));
        body_ax = '0;
        body_ay = '0;
      end
      gbi_pkg::ACT_RESTART: begin
        body_px = cfg_pos_x;
        body_py = cfg_pos_y;
        body_vx = cfg_vel_x;
        body_vy = cfg_vel_y;
        body_ax = '0;
        body_ay = '0;
      end
      default: ;
    endcase
    w.pos_x = body_px;
    w.pos_y = body_py;
    w.vel_x = body_vx;
    w.vel_y = body_vy;
    w.coincident = coin;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    body_word_t want, got;
    if (!rst_ni) begin
      cfg_pos_x <= '0; cfg_pos_y <= '0; cfg_vel_x <= '0; cfg_vel_y <= '0;
      cfg_grav <= gbi_pkg::GRAV_SCALE_RESET;
      body_px = '0; body_py = '0; body_vx = '0; body_vy = '0;
      body_ax = '0; body_ay = '0;
      fail_count <= 0;
      body_state_q.delete();
    end else begin
      // result word first, its item was taken on an earlier edge
      if (out_w.valid && out_w.ready) begin
        got.pos_x = out_w.pos_x;
        got.pos_y = out_w.pos_y;
        got.vel_x = out_w.vel_x;
        got.vel_y = out_w.vel_y;
        got.coincident = out_w.coincident;
        if (body_state_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = body_state_q.pop_front();
          if (want.pos_x !== got.pos_x || want.pos_y !== got.pos_y ||
              want.vel_x !== got.vel_x || want.vel_y !== got.vel_y ||
              want.coincident !== got.coincident) begin
            if (fail_count < 10) $display("result mismatch: expected %p, got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_w.valid && cfg_w.ready) begin
        case (gbi_pkg::gbi_cfg_idx_e'(cfg_w.index))
          gbi_pkg::CFG_START_POS_X: cfg_pos_x <= cfg_w.data[31:0];
          gbi_pkg::CFG_START_POS_Y: cfg_pos_y <= cfg_w.data[31:0];
          gbi_pkg::CFG_START_VEL_X: cfg_vel_x <= cfg_w.data[31:0];
          gbi_pkg::CFG_START_VEL_Y: cfg_vel_y <= cfg_w.data[31:0];
          gbi_pkg::CFG_GRAV_SCALE:  cfg_grav  <= cfg_w.data;
          default: ;
        endcase
      end
      if (in_w.valid && in_w.ready) begin
        advance_body(in_w.action, in_w.other_x, in_w.other_y, in_w.other_mass, want);
        body_state_q.push_back(want);
      end
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb.sv
// tb: clock, reset and stimulus for the gravity body integrator, verdict at the end
// depends on gbi_pkg, gbi_if, gravity_body_integrator and gbi_checker
`default_nettype none

module tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 200;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   no_gaps;
  int   idle_cycles = 0;
  int   n_grav, n_tick, n_restart, n_unused, n_phase;
  logic signed [31:0] home_x, home_y;

  gbi_in_if  in_w ();
  gbi_out_if out_w ();
  gbi_cfg_if cfg_w ();

  gravity_body_integrator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w),
    .cfg_i  (cfg_w)
  );

  gbi_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_w       (in_w),
    .out_w      (out_w),
    .cfg_w      (cfg_w),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready) ||
        (cfg_w.valid && cfg_w.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side stalls
  initial begin
    int stall;
    out_w.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_w.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_w.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_w.valid) @(posedge clk_i);
    end
  end

  task automatic send_word(input gbi_pkg::gbi_action_e act, input logic signed [31:0] ox,
                           input logic signed [31:0] oy, input logic [31:0] om);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_w.valid      <= 1'b1;
    in_w.action     <= act;
    in_w.other_x    <= ox;
    in_w.other_y    <= oy;
    in_w.other_mass <= om;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    case (act)
      gbi_pkg::ACT_GRAVITY: n_grav++;
      gbi_pkg::ACT_TICK:    n_tick++;
      gbi_pkg::ACT_RESTART: n_restart++;
      default:              n_unused++;
    endcase
  endtask

  // hold the sender until every result is back and the block has gone quiet
  task automatic drain();
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [47:0] vals[6]);
    for (int i = 0; i < 6; i++) begin
      cfg_w.valid <= 1'b1;
      cfg_w.index <= 3'(i);
      cfg_w.data  <= vals[i];
      @(posedge clk_i);
      while (!cfg_w.ready) @(posedge clk_i);
    end
    cfg_w.valid <= 1'b0;
    home_x = vals[gbi_pkg::CFG_START_POS_X][31:0];
    home_y = vals[gbi_pkg::CFG_START_POS_Y][31:0];
    n_phase++;
  endtask

  function automatic logic [47:0] pick32(input logic signed [31:0] lo_v,
                                         input logic signed [31:0] hi_v);
    case ($urandom_range(0, 5))
      0: return 48'(lo_v);
      1: return 48'(hi_v);
      2: return 48'(32'($urandom));
      default: return 48'(32'($urandom_range(0, 1 << 24)) - 32'(1 << 23));
    endcase
  endfunction

  function automatic logic signed [31:0] near(input logic signed [31:0] c, input int span);
    return c + 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  initial begin
    logic [47:0] regs[6];
    logic [31:0] m;
    int          r;
    rst_ni          = 1'b0;
    in_w.valid     <= 1'b0;
    in_w.action    <= gbi_pkg::ACT_TICK;
    in_w.other_x   <= '0;
    in_w.other_y   <= '0;
    in_w.other_mass <= '0;
    cfg_w.valid    <= 1'b0;
    cfg_w.index    <= '0;
    cfg_w.data     <= '0;
    no_gaps         = 1'b0;
    home_x = '0; home_y = '0;
    n_grav = 0; n_tick = 0; n_restart = 0; n_unused = 0; n_phase = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset values first, then a moderate setting
    send_word(gbi_pkg::ACT_GRAVITY, 32'sd4096, -32'sd8192, 32'hffffffff);
    send_word(gbi_pkg::ACT_GRAVITY, 32'sd0, 32'sd0, 32'd5);  // coincident at reset position
    send_word(gbi_pkg::ACT_TICK, '0, '0, '0);
    drain();
    regs = '{48'(32'sh0010_0000), 48'(-32'sh0020_0000), 48'd4096, 48'(-32'sd4096),
             48'd1000, 48'h0000_0100_0000};
    write_regs(regs);
    send_word(gbi_pkg::ACT_RESTART, '0, '0, '0);
    send_word(gbi_pkg::ACT_GRAVITY, home_x, home_y, 32'd77);     // coincident body
    send_word(gbi_pkg::ACT_GRAVITY, home_x + 32'sd4096, home_y, 32'd1_000_000_000);
    send_word(gbi_pkg::ACT_GRAVITY, home_x, home_y - 32'sd40960, 32'd123456);
    send_word(gbi_pkg::ACT_GRAVITY, home_x - 32'sd1, home_y + 32'sd1, 32'd0);  // massless
    send_word(gbi_pkg::ACT_GRAVITY, home_x + 32'sd1, home_y, 32'hffffffff);    // saturated
    send_word(gbi_pkg::ACT_GRAVITY, 32'sh7fffffff, 32'sh80000000, 32'hffffffff);
    send_word(gbi_pkg::ACT_GRAVITY, 32'sh80000000, 32'sh7fffffff, 32'd1);
    send_word(gbi_pkg::ACT_TICK, '0, '0, '0);
    send_word(gbi_pkg::ACT_UNUSED, 32'sh7fffffff, 32'sh7fffffff, 32'hffffffff);
    send_word(gbi_pkg::ACT_TICK, '0, '0, '0);
    drain();
    // extremes: largest start values and constant, then smallest
    regs = '{48'(32'sh7fffffff), 48'(32'sh7fffffff), 48'(32'sh7fffffff),
             48'(32'sh7fffffff), 48'hffffffff, 48'hffff_ffff_ffff};
    write_regs(regs);
    send_word(gbi_pkg::ACT_RESTART, '0, '0, '0);
    send_word(gbi_pkg::ACT_GRAVITY, 32'sh80000000, 32'sh80000000, 32'hffffffff);
    send_word(gbi_pkg::ACT_GRAVITY, 32'sh7ffffffe, 32'sh7fffffff, 32'hffffffff);
    send_word(gbi_pkg::ACT_TICK, '0, '0, '0);
    send_word(gbi_pkg::ACT_TICK, '0, '0, '0);
    drain();
    regs = '{48'(32'sh80000000), 48'(32'sh80000000), 48'(32'sh80000000),
             48'(32'sh80000000), 48'd1, 48'd0};
    write_regs(regs);
    send_word(gbi_pkg::ACT_RESTART, '0, '0, '0);
    send_word(gbi_pkg::ACT_GRAVITY, 32'sh7fffffff, 32'sh7fffffff, 32'hffffffff);  // zero G
    send_word(gbi_pkg::ACT_TICK, '0, '0, '0);
    send_word(gbi_pkg::ACT_TICK, '0, '0, '0);
    drain();

    // random phases: mostly pulls and ticks, a few restarts and unused words, random content
    for (int ph = 0; ph < 8; ph++) begin
      regs[gbi_pkg::CFG_START_POS_X] = pick32(32'sh80000000, 32'sh7fffffff);
      regs[gbi_pkg::CFG_START_POS_Y] = pick32(32'sh80000000, 32'sh7fffffff);
      regs[gbi_pkg::CFG_START_VEL_X] = pick32(32'sh80000000, 32'sh7fffffff);
      regs[gbi_pkg::CFG_START_VEL_Y] = pick32(32'sh80000000, 32'sh7fffffff);
      m = $urandom;
      regs[gbi_pkg::CFG_OWN_MASS]    = 48'(m == 0 ? 32'd1 : m);
      case ($urandom_range(0, 3))
        0: regs[gbi_pkg::CFG_GRAV_SCALE] = 48'(gbi_pkg::GRAV_SCALE_RESET);
        1: regs[gbi_pkg::CFG_GRAV_SCALE] = 48'hffff_ffff_ffff;
        default: regs[gbi_pkg::CFG_GRAV_SCALE] = {16'($urandom), 32'($urandom)};
      endcase
      write_regs(regs);
      no_gaps = (ph % 3 == 2);
      for (int k = 0; k < 250; k++) begin
        r = $urandom_range(0, 99);
        if (k == 0 || r < 6) begin
          send_word(gbi_pkg::ACT_RESTART, 32'($urandom), 32'($urandom), 32'($urandom));
          if ($urandom_range(0, 3) == 0)
            send_word(gbi_pkg::ACT_GRAVITY, home_x, home_y, 32'($urandom));
        end else if (r < 60) begin
          case ($urandom_range(0, 4))
            0: send_word(gbi_pkg::ACT_GRAVITY, 32'($urandom), 32'($urandom),
                         32'($urandom));
            1: send_word(gbi_pkg::ACT_GRAVITY, near(home_x, 64), near(home_y, 64),
                         32'($urandom));
            default: send_word(gbi_pkg::ACT_GRAVITY, near(home_x, 1 << 22),
                               near(home_y, 1 << 22), 32'($urandom_range(0, 1 << 20)));
          endcase
        end else if (r < 95) begin
          send_word(gbi_pkg::ACT_TICK, 32'($urandom), 32'($urandom), 32'($urandom));
        end else begin
          send_word(gbi_pkg::ACT_UNUSED, 32'($urandom), 32'($urandom), 32'($urandom));
        end
      end
      no_gaps = 1'b0;
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d gravity, %0d tick, %0d restart and %0d unused words",
             n_grav, n_tick, n_restart, n_unused);
    $display("over %0d register settings, %0d result mismatches", n_phase, fail_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
